// ===== hdl/iprf_pkg.sv =====
// ----------------------------------------------------------------------------
// iprf_pkg: shared types and constants for the packet rule filter
// Holds field widths, payload structs, mode and action codes, match helpers.
// ----------------------------------------------------------------------------
package iprf_pkg;

  localparam int MaxRules   = 64;
  localparam int SlotW      = $clog2(MaxRules);
  localparam int RuleIdxW   = SlotW + 1;
  localparam int RuleWords  = 4;
  localparam int StoreDepth = 2 * MaxRules * RuleWords;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int CntDepth   = 2 * MaxRules;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 7;

  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInCnt  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgOutCnt = 2'd2;

  localparam logic [7:0] ProtoTcp  = 8'd6;
  localparam logic [7:0] ProtoUdp  = 8'd17;
  localparam logic [7:0] ProtoIcmp = 8'd1;

  // word 3 of a rule carries action, ops and flags
  localparam logic [1:0] WordCtrl   = 2'd3;
  // no global counter sits at this index
  localparam logic [1:0] GlobNone   = 2'd3;
  localparam logic [1:0] KindTcpUdp = 2'd1;

  typedef enum logic [1:0] {
    ModeWrite = 2'd0,
    ModeCheck = 2'd1,
    ModeRdRule = 2'd2,
    ModeRdGlob = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ActPass  = 2'd0,
    ActBlock = 2'd1,
    ActLog   = 2'd2,
    ActCount = 2'd3
  } act_e;

  typedef enum logic [3:0] {
    OpNone = 4'd0, OpEq = 4'd1, OpNe = 4'd2, OpLt = 4'd3, OpGt = 4'd4,
    OpLe = 4'd5, OpGe = 4'd6, OpIn = 4'd7, OpRange = 4'd8
  } port_op_e;

  typedef enum logic [3:0] {
    StClear, StIdle, StRd0, StRd1, StRd2, StRd3, StWait, StEval,
    StCntRd, StCntWait, StCntWr, StNext, StOut
  } state_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  rule_word_addr;
    logic [63:0] rule_word;
    logic        direction;
    logic [3:0]  iface_id;
    logic [7:0]  ip_proto;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [31:0] port_pair;
    logic [23:0] l4_fields;
    logic [5:0]  header_status;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic        verdict;
    logic        log_match;
    logic [31:0] count_value;
    logic [47:0] byte_value;
  } out_item_t;

  function automatic logic port_ok(input logic [15:0] p, input logic [3:0] op,
                                   input logic [15:0] lo, input logic [15:0] hi);
    logic r;
    case (op)
      OpNone:  r = 1'b1;
      OpEq:    r = (p == lo);
      OpNe:    r = (p != lo);
      OpLt:    r = (p < lo);
      OpGt:    r = (p > lo);
      OpLe:    r = (p <= lo);
      OpGe:    r = (p >= lo);
      OpIn:    r = (p > lo) && (p < hi);
      OpRange: r = (p >= lo) && (p <= hi);
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic addr_ok(input logic [63:0] w, input logic [31:0] a,
                                   input logic neg);
    logic m;
    m = ((a & w[63:32]) == (w[31:0] & w[63:32]));
    if (w == 64'd0) return 1'b1;
    return neg ? ~m : m;
  endfunction

endpackage

// ===== hdl/ip_packet_rule_filter_unit.sv =====
// ----------------------------------------------------------------------------
// ip_packet_rule_filter_unit: IPv4 packet rule filter
// Rule words in a RAM, per-rule hit and byte counters in a second RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in      | input     | in_valid_i / in_ready_o, in_item_i
//  out     | output    | out_valid_o / out_ready_i, out_item_o
//  cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i
// A check walks the rules in turn: four word reads, a wait, evaluate and advance
// for each, plus a counter read-modify-write on a matching one. Each check also
// passes through accept, the final limit test and the output load.
// Writes and global reads finish from StRd0, rule counter reads from StCntWait.
// After reset a pass zeroes all 128 counter entries; no item is accepted meanwhile.
// The result sits in an output register; the next item is taken once it is gone.
module ip_packet_rule_filter_unit
  import iprf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o
);
  state_e         state_q, state_d;
  in_item_t       pkt_q, pkt_d;
  out_item_t      res_q, res_d;
  logic           out_valid_q, out_valid_d;
  logic           en_q;
  logic [6:0]     in_cnt_q, out_cnt_q;
  logic [RuleIdxW-1:0] idx_q, idx_d;   // rule within list
  logic [RuleIdxW:0]   lim;
  logic [63:0]    w_q [RuleWords];
  logic [63:0]    w_d [RuleWords];
  logic [31:0]    glob_q [3];
  logic [31:0]    glob_d [3];
  logic           match;

  logic                store_we;
  logic [StoreAw-1:0]  store_addr;
  logic [63:0]         store_wdata, store_rdata;
  logic                cnt_we;
  logic [RuleIdxW-1:0] cnt_addr;
  logic [79:0]         cnt_wdata, cnt_rdata;
  logic [1:0]          rd_word_q, rd_word_d;

  iprf_ram #(.Width(64), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(store_we), .addr_i(store_addr), .wdata_i(store_wdata),
    .rdata_o(store_rdata));
  iprf_ram #(.Width(80), .Depth(CntDepth)) u_cnt (
    .clk_i, .we_i(cnt_we), .addr_i(cnt_addr), .wdata_i(cnt_wdata),
    .rdata_o(cnt_rdata));

  iprf_match u_match (
    .pkt_i(pkt_q), .w0_i(w_q[0]), .w1_i(w_q[1]), .w2_i(w_q[2]), .w3_i(w_q[3]),
    .match_o(match));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      in_cnt_q <= '0;
      out_cnt_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgEnable: en_q <= cfg_data_i[0];
        CfgInCnt:  in_cnt_q <= cfg_data_i;
        CfgOutCnt: out_cnt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      for (int g = 0; g < 3; g++) glob_q[g] <= '0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      idx_q <= idx_d;
      glob_q <= glob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pkt_q <= pkt_d;
    res_q <= res_d;
    w_q <= w_d;
    rd_word_q <= rd_word_d;
  end

  always_comb begin
    logic [6:0] n;
    n = pkt_q.direction ? out_cnt_q : in_cnt_q;
    lim = (n > 7'(MaxRules)) ? (RuleIdxW+1)'(MaxRules) : (RuleIdxW+1)'(n);
  end

  assign in_ready_o  = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  always_comb begin
    logic [5:0]          slot;
    logic                slot_ok;
    logic [RuleIdxW-1:0] rule;
    state_d = state_q;
    pkt_d = pkt_q;
    res_d = res_q;
    w_d = w_q;
    glob_d = glob_q;
    idx_d = idx_q;
    rd_word_d = rd_word_q;
    out_valid_d = out_valid_q && !out_ready_i;
    store_we = 1'b0;
    store_wdata = pkt_q.rule_word;
    cnt_we = 1'b0;
    cnt_wdata = '0;
    slot = pkt_q.rule_word_addr[7:2];
    slot_ok = ({1'b0, slot} < 7'(MaxRules));
    rule = {pkt_q.rule_word_addr[8], slot[SlotW-1:0]};
    store_addr = {pkt_q.direction, idx_q[SlotW-1:0], rd_word_q};
    cnt_addr = {pkt_q.direction, idx_q[SlotW-1:0]};
    case (state_q)
      StClear: begin
        // sweep the counter RAM to zero
        cnt_we = 1'b1;
        cnt_addr = idx_q;
        idx_d = idx_q + 1'b1;
        if (idx_q == RuleIdxW'(CntDepth - 1)) begin
          idx_d = '0;
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          pkt_d = in_item_i;
          res_d = '0;
          idx_d = '0;
          rd_word_d = '0;
          state_d = StRd0;
        end
      end
      StRd0: begin
        case (mode_e'(pkt_q.mode))
          ModeWrite: begin
            store_addr = {pkt_q.rule_word_addr[8], slot[SlotW-1:0],
                          pkt_q.rule_word_addr[1:0]};
            store_we = slot_ok;
            cnt_addr = rule;
            cnt_we = slot_ok && (pkt_q.rule_word_addr[1:0] == WordCtrl);
            state_d = StOut;
          end
          ModeRdRule: begin
            cnt_addr = rule;
            state_d = StCntWait;
          end
          ModeRdGlob: begin
            if (pkt_q.rule_word_addr[1:0] != GlobNone)
              res_d.count_value = glob_q[pkt_q.rule_word_addr[1:0]];
            state_d = StOut;
          end
          default: begin
            if (!en_q || !pkt_q.header_status[0] || {1'b0, idx_q} >= lim) begin
              state_d = StOut;
            end else begin
              rd_word_d = 2'd1;
              state_d = StRd1;
            end
          end
        endcase
      end
      StRd1, StRd2, StRd3, StWait: begin
        // one word in, one read out each cycle
        w_d[rd_word_q - 2'd1] = store_rdata;
        rd_word_d = rd_word_q + 2'd1;
        case (state_q)
          StRd1:   state_d = StRd2;
          StRd2:   state_d = StRd3;
          StRd3:   state_d = StWait;
          default: state_d = StEval;
        endcase
      end
      StEval: begin
        if (match) begin
          case (act_e'(w_q[3][1:0]))
            ActBlock: begin res_d.verdict = 1'b1; glob_d[0] = glob_q[0] + 32'd1; end
            ActPass:  begin res_d.verdict = 1'b0; glob_d[1] = glob_q[1] + 32'd1; end
            ActLog:   begin res_d.log_match = 1'b1; glob_d[2] = glob_q[2] + 32'd1; end
            default: ;
          endcase
          state_d = StCntRd;
        end else begin
          state_d = StNext;
        end
      end
      StCntRd: state_d = StCntWr;
      StCntWr: begin
        cnt_we = 1'b1;
        cnt_wdata = {cnt_rdata[79:48] + 32'd1,
                     cnt_rdata[47:0] + {32'd0, pkt_q.packet_length}};
        if (w_q[3][62] && w_q[3][1:0] != ActCount) state_d = StOut;
        else state_d = StNext;
      end
      StNext: begin
        idx_d = idx_q + 1'b1;
        rd_word_d = '0;
        state_d = StRd0;
      end
      StCntWait: begin
        cnt_addr = rule;
        if (slot_ok) begin
          res_d.count_value = cnt_rdata[79:48];
          res_d.byte_value = cnt_rdata[47:0];
        end
        state_d = StOut;
      end
      StOut: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule

// ===== hdl/iprf_ram.sv =====
// ----------------------------------------------------------------------------
// iprf_ram: generic single-port synchronous RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module iprf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hdl/iprf_match.sv =====
// ----------------------------------------------------------------------------
// iprf_match: rule match logic
// Tests one assembled rule (four words) against the packet fields.
// ----------------------------------------------------------------------------
module iprf_match
  import iprf_pkg::*;
(
  input  in_item_t    pkt_i,
  input  logic [63:0] w0_i,
  input  logic [63:0] w1_i,
  input  logic [63:0] w2_i,
  input  logic [63:0] w3_i,
  output logic        match_o
);
  logic        tcpudp;
  logic [15:0] sp, dp;
  logic [7:0]  pr;
  logic [5:0]  hs;
  logic [3:0]  rif, sop, dop;
  logic [1:0]  kind;
  logic [7:0]  fm;

  always_comb begin
    pr     = pkt_i.ip_proto;
    hs     = pkt_i.header_status;
    tcpudp = (pr == ProtoTcp) || (pr == ProtoUdp);
    sp     = (tcpudp && hs[1]) ? pkt_i.port_pair[31:16] : 16'd0;
    dp     = (tcpudp && hs[1]) ? pkt_i.port_pair[15:0] : 16'd0;
    rif    = w3_i[5:2];
    kind   = w3_i[7:6];
    sop    = w3_i[21:18];
    dop    = w3_i[25:22];
    fm     = w3_i[33:26];
    match_o = 1'b1;
    if (rif != 4'd0 && rif != pkt_i.iface_id) match_o = 1'b0;
    if (kind == KindTcpUdp && !tcpudp) match_o = 1'b0;
    if (kind[1] && w3_i[15:8] != pr) match_o = 1'b0;
    if (!addr_ok(w0_i, pkt_i.ip_src, w3_i[16])) match_o = 1'b0;
    if (!addr_ok(w1_i, pkt_i.ip_dst, w3_i[17])) match_o = 1'b0;
    if (sop != OpNone && (!tcpudp || !port_ok(sp, sop, w2_i[15:0], w2_i[31:16])))
      match_o = 1'b0;
    if (dop != OpNone && (!tcpudp || !port_ok(dp, dop, w2_i[47:32], w2_i[63:48])))
      match_o = 1'b0;
    if (fm != 8'd0) begin
      if (pr != ProtoTcp || !hs[2]) match_o = 1'b0;
      if ((pkt_i.l4_fields[23:16] & fm) != w3_i[41:34]) match_o = 1'b0;
    end
    if (w3_i[42]) begin
      if (pr != ProtoIcmp || !hs[3]) match_o = 1'b0;
      if (pkt_i.l4_fields[15:8] != w3_i[50:43]) match_o = 1'b0;
      if (w3_i[51] && pkt_i.l4_fields[7:0] != w3_i[59:52]) match_o = 1'b0;
    end
    if (w3_i[60] && tcpudp && hs[4]) match_o = 1'b0;
    if (w3_i[61] && !hs[5]) match_o = 1'b0;
  end
endmodule
